// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== rtl/trph_pkg.sv =====
// ----------------------------------------------------------------------------
// trph_pkg
// Types and constants shared by the tree routing packet handler modules.
// ----------------------------------------------------------------------------
package trph_pkg;

	localparam int ROUTE_ENTRIES = 64;

	localparam logic [7:0]         RANK_RESET   = 8'd255;
	localparam logic [7:0]         RANK_KEEP    = 8'd2;
	localparam logic signed [10:0] RSSI_RESET   = -11'sd1000;
	localparam logic [15:0]        PARENT_RESET = 16'h0000;
	localparam logic [15:0]        PARENT_LOST  = 16'h0100;
	localparam logic [6:0]         GOOD_LENGTH  = 7'd6;
	localparam logic [7:0]         CAST_BCAST   = 8'd0;

	localparam logic [7:0] MSG_ANNOUNCE = 8'd0;
	localparam logic [7:0] MSG_PDOWN    = 8'd1;
	localparam logic [7:0] MSG_DATA     = 8'd2;
	localparam logic [7:0] MSG_VALVE    = 8'd3;

	localparam logic REG_ADDR_LO = 1'b0;
	localparam logic REG_ADDR_HI = 1'b1;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_UPDATE,
		OP_INSERT
	} op_t;

	typedef enum logic [2:0] {
		ACT_ANNOUNCE,
		ACT_PDOWN,
		ACT_FORWARD,
		ACT_VALVE,
		ACT_CMD_UNI,
		ACT_CMD_BCAST
	} act_t;

	// Search token handed from cell to cell along the routing table.
	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [15:0] target;
		logic [15:0] src;
		logic        done;
		logic [15:0] hop;
	} tok_t;

endpackage

// ===== rtl/trph_cell.sv =====
// ----------------------------------------------------------------------------
// trph_cell
// One routing table entry; matches, updates or fills on the passing token.
// ----------------------------------------------------------------------------
module trph_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_all,
	input  trph_pkg::tok_t tok_in,
	output trph_pkg::tok_t tok_out
);
	import trph_pkg::*;

	logic        alive_q;
	logic [15:0] target_q;
	logic [15:0] hop_q;
	tok_t        tok_q;
	tok_t        tok_nxt;
	logic        match;
	logic        wr_hop;
	logic        wr_ins;

	assign match = alive_q && (target_q == tok_in.target);

	always_comb begin
		tok_nxt = tok_in;
		wr_hop  = 1'b0;
		wr_ins  = 1'b0;
		if (tok_in.valid && !tok_in.done) begin
			case (tok_in.op)
				OP_LOOKUP: begin
					if (match) begin
						tok_nxt.done = 1'b1;
						tok_nxt.hop  = hop_q;
					end
				end
				OP_UPDATE: begin
					if (match) begin
						tok_nxt.done = 1'b1;
						wr_hop       = 1'b1;
					end
				end
				OP_INSERT: begin
					// claim the first free entry
					if (!alive_q) begin
						tok_nxt.done = 1'b1;
						wr_ins       = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (clear_all)
				alive_q <= 1'b0;
			else if (wr_ins)
				alive_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ins) begin
			target_q <= tok_in.target;
			hop_q    <= tok_in.src;
		end else if (wr_hop) begin
			hop_q <= tok_in.src;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/trph_chain.sv =====
// ----------------------------------------------------------------------------
// trph_chain
// Row of routing table cells; a token enters at the head, leaves at the tail.
// ----------------------------------------------------------------------------
module trph_chain (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_all,
	input  trph_pkg::tok_t head,
	output trph_pkg::tok_t tail
);
	import trph_pkg::*;

	tok_t link [ROUTE_ENTRIES+1];

	assign link[0] = head;

	for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
		trph_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear_all (clear_all),
			.tok_in    (link[i]),
			.tok_out   (link[i+1])
		);
	end

	assign tail = link[ROUTE_ENTRIES];

endmodule

// ===== rtl/tree_routing_packet_handler.sv =====
// Timing: broadcast packets and commands for the own address give their results from the
// decide state; other data and command packets give theirs once the token leaves the cell row.
// A new data route that misses takes two passes: an update pass, then an insert pass.
// Throughput: one packet at a time; the next is taken only once the last one's results are
// queued, and not while the result queue holds more than two results.
// Reset: arst_n clears rank, parent, alive bits, own address and the result queue.
// ----------------------------------------------------------------------------
// tree_routing_packet_handler
// Tree network packet handler: parent selection, route learning, command routing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tree_routing_packet_handler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// packet_length[6:0] sender_rank[14:7] target_lo[22:15] target_hi[30:23]
	// payload_value[38:31] src_lo[46:39] src_hi[54:47] rssi[62:55] zero[63]
	input  logic [63:0] s_tdata,
	// cast_kind[7:0] msg_type[15:8]
	input  logic [15:0] s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// dest_lo[7:0] dest_hi[15:8] fwd_target_lo[23:16] fwd_target_hi[31:24]
	// fwd_value[39:32] node_rank[47:40] learn_dropped[48] zero[55:49]
	output logic [55:0] m_tdata,
	// action[2:0]
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);
	import trph_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WAIT_UPD,
		ST_WAIT_INS,
		ST_WAIT_LK
	} state_t;

	typedef struct packed {
		act_t        action;
		logic [15:0] dest;
		logic [15:0] fwd_target;
		logic [7:0]  value;
		logic [7:0]  rank;
		logic        dropped;
		logic        last;
	} res_t;

	state_t state_q;

	logic [15:0]        own_q;
	logic [7:0]         rank_q;
	logic signed [10:0] parent_rssi_q;
	logic [15:0]        parent_q;
	logic               clear_q;
	tok_t               launch_q;
	tok_t               launch_d;
	logic               clear_d;
	tok_t               tail;
	logic               tok_wait;

	logic [6:0]  len_q;
	logic [7:0]  cast_q;
	logic [7:0]  type_q;
	logic [7:0]  srank_q;
	logic [15:0] target_q;
	logic [7:0]  value_q;
	logic [15:0] src_q;
	logic [7:0]  rssi_q;

	// result queue
	res_t       qmem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] push_n;
	res_t       ent0;
	res_t       ent1;
	logic       pop;

	logic               len_ok;
	logic               bcast;
	logic signed [10:0] rssi_ext;
	logic               adopt;
	logic               pd_parent;
	logic               pd_reset;
	logic [7:0]         rank_after;
	logic               pd_deep;
	logic               data_ok;
	logic               cmd_ok;
	logic               cmd_own;
	res_t               fwd_res;

	assign s_tready = (state_q == ST_IDLE) && (count_q <= 3'd2);
	assign pop      = m_tvalid && m_tready;
	assign tok_wait = (state_q == ST_WAIT_UPD) || (state_q == ST_WAIT_INS)
	                  || (state_q == ST_WAIT_LK);

	assign len_ok    = (len_q == GOOD_LENGTH);
	assign bcast     = (cast_q == CAST_BCAST);
	assign rssi_ext  = {{3{rssi_q[7]}}, rssi_q};
	assign adopt     = bcast && (type_q == MSG_ANNOUNCE) && (srank_q < rank_q)
	                   && (parent_rssi_q < rssi_ext);
	assign pd_parent = bcast && (type_q == MSG_PDOWN) && (parent_q == src_q);
	assign pd_reset  = pd_parent && (rank_q != RANK_KEEP);
	assign rank_after = pd_reset ? RANK_RESET : rank_q;
	assign pd_deep   = bcast && (type_q == MSG_PDOWN) && (srank_q > rank_after);
	assign data_ok   = !bcast && (type_q == MSG_DATA)
	                   && ({1'b0, srank_q} == ({1'b0, rank_q} + 9'd1));
	assign cmd_ok    = !bcast && (type_q == MSG_VALVE) && (rank_q != 8'd0)
	                   && (srank_q == (rank_q - 8'd1));
	assign cmd_own   = (target_q == own_q);

	always_comb begin
		fwd_res            = '0;
		fwd_res.action     = ACT_FORWARD;
		fwd_res.dest       = parent_q;
		fwd_res.fwd_target = target_q;
		fwd_res.value      = value_q;
		fwd_res.rank       = rank_q;
		fwd_res.last       = 1'b1;
	end

	// results produced this cycle
	always_comb begin
		push_n = 2'd0;
		ent0   = '0;
		ent1   = '0;
		case (state_q)
			ST_DECIDE: begin
				if (len_ok) begin
					if (adopt) begin
						push_n          = 2'd1;
						ent0.action     = ACT_ANNOUNCE;
						ent0.fwd_target = own_q;
						ent0.rank       = srank_q + 8'd1;
						ent0.last       = 1'b1;
					end else if (pd_parent) begin
						push_n          = pd_deep ? 2'd2 : 2'd1;
						ent0.action     = ACT_PDOWN;
						ent0.fwd_target = own_q;
						ent0.rank       = rank_after;
						ent0.last       = !pd_deep;
						ent1.action     = ACT_ANNOUNCE;
						ent1.fwd_target = own_q;
						ent1.rank       = rank_after;
						ent1.last       = 1'b1;
					end else if (pd_deep) begin
						push_n          = 2'd1;
						ent0.action     = ACT_ANNOUNCE;
						ent0.fwd_target = own_q;
						ent0.rank       = rank_q;
						ent0.last       = 1'b1;
					end else if (cmd_ok && cmd_own) begin
						push_n          = 2'd1;
						ent0.action     = ACT_VALVE;
						ent0.fwd_target = target_q;
						ent0.value      = value_q;
						ent0.rank       = rank_q;
						ent0.last       = 1'b1;
					end
				end
			end
			ST_WAIT_UPD: begin
				if (tail.valid && tail.done) begin
					push_n = 2'd1;
					ent0   = fwd_res;
				end
			end
			ST_WAIT_INS: begin
				if (tail.valid) begin
					push_n       = 2'd1;
					ent0         = fwd_res;
					ent0.dropped = !tail.done;
				end
			end
			ST_WAIT_LK: begin
				if (tail.valid) begin
					push_n          = 2'd1;
					ent0.action     = tail.done ? ACT_CMD_UNI : ACT_CMD_BCAST;
					ent0.dest       = tail.done ? tail.hop : 16'h0000;
					ent0.fwd_target = target_q;
					ent0.value      = value_q;
					ent0.rank       = rank_q;
					ent0.last       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// token launched into the cell row and table clear for the next cycle
	always_comb begin
		launch_d = '0;
		clear_d  = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				if (len_ok) begin
					if (data_ok) begin
						launch_d.valid  = 1'b1;
						launch_d.op     = OP_UPDATE;
						launch_d.target = target_q;
						launch_d.src    = src_q;
					end else if (cmd_ok && !cmd_own) begin
						launch_d.valid  = 1'b1;
						launch_d.op     = OP_LOOKUP;
						launch_d.target = target_q;
						launch_d.src    = src_q;
					end
					clear_d = pd_reset;
				end
			end
			ST_WAIT_UPD: begin
				// no match anywhere: second pass takes the first free entry
				if (tail.valid && !tail.done) begin
					launch_d.valid  = 1'b1;
					launch_d.op     = OP_INSERT;
					launch_d.target = target_q;
					launch_d.src    = src_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_q         <= 16'h0000;
			rank_q        <= RANK_RESET;
			parent_rssi_q <= RSSI_RESET;
			parent_q      <= PARENT_RESET;
			clear_q       <= 1'b0;
			launch_q      <= '0;
		end else begin
			clear_q  <= clear_d;
			launch_q <= launch_d;
			if (wr_en) begin
				if (wr_index == REG_ADDR_LO)
					own_q[7:0] <= wr_data;
				else
					own_q[15:8] <= wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (len_ok && data_ok)
						state_q <= ST_WAIT_UPD;
					else if (len_ok && cmd_ok && !cmd_own)
						state_q <= ST_WAIT_LK;
					else
						state_q <= ST_IDLE;
					if (len_ok && adopt) begin
						parent_q      <= src_q;
						parent_rssi_q <= rssi_ext;
						rank_q        <= srank_q + 8'd1;
					end else if (len_ok && pd_reset) begin
						rank_q        <= RANK_RESET;
						parent_q      <= PARENT_LOST;
						parent_rssi_q <= RSSI_RESET;
					end
				end
				ST_WAIT_UPD: begin
					if (tail.valid) begin
						if (tail.done)
							state_q <= ST_IDLE;
						else
							state_q <= ST_WAIT_INS;
					end
				end
				ST_WAIT_INS, ST_WAIT_LK: begin
					if (tail.valid)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			len_q    <= s_tdata[6:0];
			srank_q  <= s_tdata[14:7];
			target_q <= s_tdata[30:15];
			value_q  <= s_tdata[38:31];
			src_q    <= s_tdata[54:39];
			rssi_q   <= s_tdata[62:55];
			cast_q   <= s_tuser[7:0];
			type_q   <= s_tuser[15:8];
		end
	end

	trph_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (clear_q),
		.head      (launch_q),
		.tail      (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			qmem[wr_ptr_q] <= ent0;
		if (push_n == 2'd2)
			qmem[wr_ptr_q + 2'd1] <= ent1;
	end

	assign m_tvalid = (count_q != 3'd0);
	assign m_tdata  = {7'b0000000, qmem[rd_ptr_q].dropped, qmem[rd_ptr_q].rank,
	                   qmem[rd_ptr_q].value, qmem[rd_ptr_q].fwd_target,
	                   qmem[rd_ptr_q].dest};
	assign m_tuser  = qmem[rd_ptr_q].action;
	assign m_tlast  = qmem[rd_ptr_q].last;

	`ASSERT_ALWAYS(a_queue_bound, count_q <= 3'd4, "result queue overflow")
	`ASSERT_IMPLIES(a_decide_room, state_q == ST_DECIDE, count_q <= 3'd2, "no room for results")
	`ASSERT_IMPLIES(a_tail_wait, tail.valid, tok_wait, "token left chain while not waiting")

endmodule

// ===== bench/trph_check.sv =====
// ----------------------------------------------------------------------------
// trph_check
// Watches the configuration port and both stream channels of the packet
// handler, predicts the reactions to every accepted packet from its own copy
// of rank, parent and routing table, and compares each result transaction
// field by field, oldest reaction first.
// ----------------------------------------------------------------------------
module trph_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [15:0] s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output logic [7:0]  rank_hint,
	output logic [15:0] parent_hint
);
	import trph_pkg::*;

	typedef struct packed {
		act_t        act;
		logic [15:0] dest;
		logic [15:0] tgt;
		logic [7:0]  val;
		logic [7:0]  rank;
		logic        drop;
		logic        last;
	} reaction_t;

	reaction_t   reactions_due[$];
	reaction_t   fresh[$];

	logic [7:0]  own_lo = '0;
	logic [7:0]  own_hi = '0;
	logic [7:0]  rank_now = RANK_RESET;
	int          parent_rssi_now = int'(RSSI_RESET);
	logic [15:0] parent_now = PARENT_RESET;
	logic [15:0] route_tgt[ROUTE_ENTRIES];
	logic [15:0] route_hop[ROUTE_ENTRIES];
	logic        route_live[ROUTE_ENTRIES];

	function automatic void clear_routes();
		for (int k = 0; k < ROUTE_ENTRIES; k++)
			route_live[k] = 1'b0;
	endfunction

	function automatic int find_route(logic [15:0] tgt);
		for (int k = 0; k < ROUTE_ENTRIES; k++)
			if (route_live[k] && route_tgt[k] == tgt)
				return k;
		return -1;
	endfunction

	function automatic void add_reaction(act_t act, logic [15:0] dest, logic [15:0] tgt,
			logic [7:0] val, logic drop);
		reaction_t r;
		r.act  = act;
		r.dest = dest;
		r.tgt  = tgt;
		r.val  = val;
		r.rank = rank_now;
		r.drop = drop;
		r.last = 1'b0;
		fresh.push_back(r);
	endfunction

	function automatic void react_to_packet(logic [63:0] d, logic [15:0] u);
		logic [6:0]  len;
		logic [7:0]  cast, mtype, srank, val;
		logic [15:0] tgt, src, own;
		int          rssi, hit;
		logic        drop;
		reaction_t   r;
		len   = d[6:0];
		srank = d[14:7];
		tgt   = d[30:15];
		val   = d[38:31];
		src   = d[54:39];
		rssi  = int'($signed(d[62:55]));
		cast  = u[7:0];
		mtype = u[15:8];
		own   = {own_hi, own_lo};
		if (len != GOOD_LENGTH)
			return;
		if (cast == CAST_BCAST) begin
			if (mtype == MSG_ANNOUNCE && srank < rank_now && parent_rssi_now < rssi) begin
				parent_now = src;
				parent_rssi_now = rssi;
				rank_now = srank + 8'd1;
				add_reaction(ACT_ANNOUNCE, 16'h0, own, 8'h0, 1'b0);
			end
			if (mtype == MSG_PDOWN && parent_now == src) begin
				// a rank-2 node keeps its parent
				if (rank_now != RANK_KEEP) begin
					rank_now = RANK_RESET;
					parent_now = PARENT_LOST;
					parent_rssi_now = int'(RSSI_RESET);
					clear_routes();
				end
				add_reaction(ACT_PDOWN, 16'h0, own, 8'h0, 1'b0);
			end
			if (mtype == MSG_PDOWN && srank > rank_now)
				add_reaction(ACT_ANNOUNCE, 16'h0, own, 8'h0, 1'b0);
		end else if (mtype == MSG_DATA && int'(srank) == int'(rank_now) + 1) begin
			hit = find_route(tgt);
			drop = 1'b0;
			if (hit >= 0) begin
				route_hop[hit] = src;
			end else begin
				drop = 1'b1;
				for (int k = 0; k < ROUTE_ENTRIES; k++)
					if (drop && !route_live[k]) begin
						route_live[k] = 1'b1;
						route_tgt[k] = tgt;
						route_hop[k] = src;
						drop = 1'b0;
					end
			end
			add_reaction(ACT_FORWARD, parent_now, tgt, val, drop);
		end else if (mtype == MSG_VALVE && rank_now >= 8'd1 &&
				int'(srank) == int'(rank_now) - 1) begin
			hit = find_route(tgt);
			if (tgt == own)
				add_reaction(ACT_VALVE, 16'h0, tgt, val, 1'b0);
			else if (hit >= 0)
				add_reaction(ACT_CMD_UNI, route_hop[hit], tgt, val, 1'b0);
			else
				add_reaction(ACT_CMD_BCAST, 16'h0, tgt, val, 1'b0);
		end
		// mark the final result of this packet
		while (fresh.size() > 0) begin
			r = fresh.pop_front();
			r.last = (fresh.size() == 0);
			reactions_due.push_back(r);
		end
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result();
		reaction_t want;
		if (reactions_due.size() == 0) begin
			$error("result transaction with no reaction pending, action %0d", m_tuser);
			errors++;
			return;
		end
		want = reactions_due.pop_front();
		compare_field("action", 16'(want.act), 16'(m_tuser));
		compare_field("dest_lo", 16'(want.dest[7:0]), 16'(m_tdata[7:0]));
		compare_field("dest_hi", 16'(want.dest[15:8]), 16'(m_tdata[15:8]));
		compare_field("fwd_target_lo", 16'(want.tgt[7:0]), 16'(m_tdata[23:16]));
		compare_field("fwd_target_hi", 16'(want.tgt[15:8]), 16'(m_tdata[31:24]));
		compare_field("fwd_value", 16'(want.val), 16'(m_tdata[39:32]));
		compare_field("node_rank", 16'(want.rank), 16'(m_tdata[47:40]));
		compare_field("learn_dropped", 16'(want.drop), 16'(m_tdata[48]));
		compare_field("last", 16'(want.last), 16'(m_tlast));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_lo = '0;
			own_hi = '0;
			rank_now = RANK_RESET;
			parent_rssi_now = int'(RSSI_RESET);
			parent_now = PARENT_RESET;
			clear_routes();
			reactions_due.delete();
			fresh.delete();
			pending <= 0;
			rank_hint <= RANK_RESET;
			parent_hint <= PARENT_RESET;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_ADDR_LO)
					own_lo = wr_data;
				else
					own_hi = wr_data;
			end
			if (s_tvalid && s_tready)
				react_to_packet(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				check_result();
			pending <= reactions_due.size();
			rank_hint <= rank_now;
			parent_hint <= parent_now;
		end
	end

endmodule

// ===== bench/tb_tree_routing_packet_handler.sv =====
// ----------------------------------------------------------------------------
// tb_tree_routing_packet_handler
// Drives the packet handler with a directed packet sequence and then with
// phases of random, mostly well-formed traffic under several node addresses,
// with random idling on both channels and one long result stall. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_tree_routing_packet_handler;
	import trph_pkg::*;

	localparam int SETTLE_CYCLES = 2 * ROUTE_ENTRIES + 16;
	localparam int STALL_CYCLES  = 3000;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [7:0]  wr_data;
	logic        s_tvalid;
	logic        s_tready;
	// packet_length[6:0] sender_rank[14:7] target_lo[22:15] target_hi[30:23]
	// payload_value[38:31] src_lo[46:39] src_hi[54:47] rssi[62:55] zero[63]
	logic [63:0] s_tdata;
	// cast_kind[7:0] msg_type[15:8]
	logic [15:0] s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// dest_lo[7:0] dest_hi[15:8] fwd_target_lo[23:16] fwd_target_hi[31:24]
	// fwd_value[39:32] node_rank[47:40] learn_dropped[48] zero[55:49]
	logic [55:0] m_tdata;
	// action[2:0]
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int          errors;
	int          pending;
	logic [7:0]  rank_hint;
	logic [15:0] parent_hint;

	logic        stall_req = 1'b0;
	bit          steady = 1'b0;
	logic [15:0] own_addr;
	logic [15:0] known_targets[$];

	tree_routing_packet_handler uut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	trph_check watch (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors), .pending(pending), .rank_hint(rank_hint), .parent_hint(parent_hint)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(30, 80);
	endfunction

	task automatic send_packet(input logic [6:0] len, input logic [7:0] cast, mtype, srank,
			input logic [15:0] tgt, input logic [7:0] val, input logic [15:0] src,
			input logic [7:0] rssi);
		int gap;
		s_tdata  <= {1'b0, rssi, src, val, tgt, srank, len};
		s_tuser  <= {mtype, cast};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait out every expected result and any table pass still running
	task automatic settle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_addr(input logic [15:0] a);
		wr_en    <= 1'b1;
		wr_index <= REG_ADDR_LO;
		wr_data  <= a[7:0];
		@(posedge clk);
		wr_index <= REG_ADDR_HI;
		wr_data  <= a[15:8];
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic random_packet(input bit fill);
		int          roll, pick;
		logic [6:0]  len;
		logic [7:0]  cast, mtype, srank, val, rssi;
		logic [15:0] tgt, src;
		roll  = fill ? $urandom_range(20, 74) : $urandom_range(0, 99);
		len   = GOOD_LENGTH;
		cast  = 8'($urandom_range(1, 255));
		mtype = 8'($urandom);
		srank = 8'($urandom);
		tgt   = 16'($urandom);
		val   = 8'($urandom);
		src   = 16'($urandom);
		rssi  = 8'($urandom);
		if (roll < 10) begin
			cast = CAST_BCAST;
			mtype = MSG_ANNOUNCE;
			if ($urandom_range(0, 3) != 0)
				srank = 8'($urandom_range(0, 4));
		end else if (roll < 20) begin
			cast = CAST_BCAST;
			mtype = MSG_PDOWN;
			if ($urandom_range(0, 3) != 0)
				src = parent_hint;
			pick = $urandom_range(0, 2);
			if (pick == 1)
				srank = rank_hint + 8'($urandom_range(1, 3));
			else if (pick == 2)
				srank = 8'($urandom_range(0, 4));
		end else if (roll < 60) begin
			mtype = MSG_DATA;
			if ($urandom_range(0, 9) != 0)
				srank = rank_hint + 8'd1;
			if (known_targets.size() > 0 && $urandom_range(0, 99) < (fill ? 30 : 50))
				tgt = known_targets[$urandom_range(0, known_targets.size() - 1)];
			known_targets.push_back(tgt);
			if (known_targets.size() > 256)
				void'(known_targets.pop_front());
		end else if (roll < 85) begin
			mtype = MSG_VALVE;
			if ($urandom_range(0, 9) != 0)
				srank = rank_hint - 8'd1;
			pick = $urandom_range(0, 9);
			if (pick < 2)
				tgt = own_addr;
			else if (pick < 6 && known_targets.size() > 0)
				tgt = known_targets[$urandom_range(0, known_targets.size() - 1)];
		end else begin
			pick = $urandom_range(0, 2);
			if (pick == 0) begin
				len = 7'($urandom_range(0, 127));
				cast = $urandom_range(0, 1) ? CAST_BCAST : 8'($urandom);
			end else if (pick == 1) begin
				mtype = 8'($urandom_range(4, 255));
				cast = $urandom_range(0, 1) ? CAST_BCAST : 8'($urandom);
			end else begin
				// data or command sent as broadcast
				cast = CAST_BCAST;
				mtype = $urandom_range(0, 1) ? MSG_DATA : MSG_VALVE;
			end
		end
		send_packet(len, cast, mtype, srank, tgt, val, src, rssi);
	endtask

	// result side: random backpressure plus one long hold-off on request
	initial begin
		int g;
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			g = idle_len();
			if (g == 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		int ph;
		bit fill;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = REG_ADDR_LO;
		wr_data  = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		own_addr = 16'h3412;
		set_addr(own_addr);

		// length filter and unknown type
		send_packet(7'd0, CAST_BCAST, MSG_ANNOUNCE, 8'd0, 16'h0, 8'h0, 16'h0, 8'h7F);
		send_packet(7'd127, 8'hFF, MSG_DATA, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
		send_packet(GOOD_LENGTH, CAST_BCAST, 8'hFF, 8'd0, 16'h0, 8'h0, 16'h0, 8'h7F);
		// parent down from the reset parent address
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_PDOWN, 8'd0, 16'h0, 8'h0, 16'h0000, 8'h00);
		// rank 255 takes no data, even from a wrapped rank
		send_packet(GOOD_LENGTH, 8'h01, MSG_DATA, 8'd0, 16'h1111, 8'h11, 16'h0202, 8'h00);
		// join at rank 2 with the weakest signal
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_ANNOUNCE, 8'd1, 16'h0, 8'h0, 16'hA001, 8'h80);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_PDOWN, 8'd0, 16'h0, 8'h0, 16'hA001, 8'h00);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_PDOWN, 8'd200, 16'h0, 8'h0, 16'h7777, 8'h00);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_PDOWN, 8'd9, 16'h0, 8'h0, 16'hA001, 8'h00);
		// learn, refresh, wrong rank
		send_packet(GOOD_LENGTH, 8'hFF, MSG_DATA, 8'd3, 16'h1111, 8'hFF, 16'h0303, 8'h7F);
		send_packet(GOOD_LENGTH, 8'h80, MSG_DATA, 8'd3, 16'h1111, 8'h00, 16'h0404, 8'h80);
		send_packet(GOOD_LENGTH, 8'h01, MSG_DATA, 8'd2, 16'h2222, 8'h22, 16'h0505, 8'h00);
		// commands: own address, known route, unknown route, wrong rank
		send_packet(GOOD_LENGTH, 8'h01, MSG_VALVE, 8'd1, 16'h3412, 8'h5A, 16'hA001, 8'h00);
		send_packet(GOOD_LENGTH, 8'h02, MSG_VALVE, 8'd1, 16'h1111, 8'hA5, 16'hA001, 8'h00);
		send_packet(GOOD_LENGTH, 8'h04, MSG_VALVE, 8'd1, 16'hDEAD, 8'h01, 16'hA001, 8'h00);
		send_packet(GOOD_LENGTH, 8'h08, MSG_VALVE, 8'd0, 16'h1111, 8'h02, 16'hA001, 8'h00);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_DATA, 8'd3, 16'h1111, 8'h03, 16'h0606, 8'h00);
		// better parent at rank 1, then lose it: full reset
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_ANNOUNCE, 8'd0, 16'h0, 8'h0, 16'hC0DE, 8'h7F);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_PDOWN, 8'd0, 16'h0, 8'h0, 16'hC0DE, 8'h00);
		send_packet(GOOD_LENGTH, 8'h10, MSG_VALVE, 8'd254, 16'h1111, 8'h04, 16'h0707, 8'h00);
		// rank 255 after a join, then back to rank 1
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_ANNOUNCE, 8'd254, 16'h0, 8'h0, 16'h0100, 8'h00);
		send_packet(GOOD_LENGTH, 8'h20, MSG_DATA, 8'd0, 16'h3333, 8'h05, 16'h0808, 8'h00);
		send_packet(GOOD_LENGTH, CAST_BCAST, MSG_ANNOUNCE, 8'd0, 16'h0, 8'h0, 16'hFFFF, 8'h7F);
		send_packet(GOOD_LENGTH, 8'h40, MSG_VALVE, 8'd0, 16'h3412, 8'h06, 16'hFFFF, 8'h00);

		for (ph = 0; ph < 12; ph++) begin
			fill = (ph % 3 == 2);
			s_tvalid <= 1'b0;
			settle();
			if (ph == 0)
				own_addr = 16'h0000;
			else if (ph == 1)
				own_addr = 16'hFFFF;
			else
				own_addr = 16'($urandom);
			set_addr(own_addr);
			steady = (ph == 6 || ph == 7);
			if (ph == 4)
				stall_req <= 1'b1;
			// announce a low-rank parent at full signal; it is taken only if the stored parent signal is weaker
			send_packet(GOOD_LENGTH, CAST_BCAST, MSG_ANNOUNCE, 8'($urandom_range(0, 3)),
				16'($urandom), 8'($urandom), 16'($urandom), 8'd127);
			repeat (fill ? 140 : 120)
				random_packet(fill);
		end

		s_tvalid <= 1'b0;
		settle();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/trph_pkg.sv
rtl/trph_cell.sv
rtl/trph_chain.sv
rtl/tree_routing_packet_handler.sv
bench/trph_check.sv
bench/tb_tree_routing_packet_handler.sv
